// ===== rtl/core/assert_macros.svh =====
// Assertion helpers for the timer core.
// Both expect clk and arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("timer assertion failed");

// Next-cycle implication.
`define ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("timer assertion failed");

`endif

// ===== rtl/core/tmr_pkg.sv =====
package tmr_pkg;

	// Channel count limits
	localparam int NUM_CHANNELS_DEF = 4;
	localparam int MAX_CH           = 4;
	localparam int CH_IDX_W         = 2;

	// Register word file
	localparam int WORD_W     = 16;
	localparam int ADDR_W     = 6;
	localparam int OFF_W      = 4;
	localparam int WORD_COUNT = 1 << ADDR_W;
	localparam int PRE_W      = 7;

	// Item kinds
	localparam logic [1:0] KIND_WRITE = 2'd0;
	localparam logic [1:0] KIND_READ  = 2'd1;
	localparam logic [1:0] KIND_TICK  = 2'd2;

	// Word offsets inside a channel block
	localparam logic [OFF_W-1:0] OFF_COMP1  = 4'd0;
	localparam logic [OFF_W-1:0] OFF_LOAD   = 4'd3;
	localparam logic [OFF_W-1:0] OFF_CNTR   = 4'd5;
	localparam logic [OFF_W-1:0] OFF_CTRL   = 4'd6;
	localparam logic [OFF_W-1:0] OFF_SCTRL  = 4'd7;
	localparam logic [OFF_W-1:0] OFF_CSCTRL = 4'd10;
	localparam logic [OFF_W-1:0] OFF_ENBL   = 4'd15;

	// The enable word lives in channel 0's block only
	localparam logic [ADDR_W-1:0] ENBL_ADDR = 6'd15;
	localparam logic [WORD_W-1:0] ENBL_RST  = 16'h0001;

	// Status and control bit masks
	localparam logic [WORD_W-1:0] SC_TCF    = 16'h8000;
	localparam logic [WORD_W-1:0] SC_TCFIE  = 16'h4000;
	localparam logic [WORD_W-1:0] SC_TOF    = 16'h2000;
	localparam logic [WORD_W-1:0] SC_TOFIE  = 16'h1000;
	localparam logic [WORD_W-1:0] CS_TCF1   = 16'h0010;
	localparam logic [WORD_W-1:0] CS_TCF2   = 16'h0020;
	localparam logic [WORD_W-1:0] CS_TCF1EN = 16'h0040;
	localparam logic [WORD_W-1:0] CS_TCF2EN = 16'h0080;
	localparam logic [WORD_W-1:0] PCS_MASK  = 16'h1E00;
	localparam logic [WORD_W-1:0] CM_MASK   = 16'hE000;
	localparam int                PCS_LSB   = 9;

	typedef struct packed {
		logic [1:0]        kind;
		logic [ADDR_W-1:0] word_address;
		logic [WORD_W-1:0] write_data;
	} req_t;

	typedef struct packed {
		logic [WORD_W-1:0] read_data;
		logic              irq_level;
	} rsp_t;

	// Per-channel command for one accepted item
	typedef struct packed {
		logic              wr_sel;
		logic              restart_all;
		logic              tick;
		logic              run_en;
		logic [OFF_W-1:0]  off;
		logic [WORD_W-1:0] data;
	} chan_cmd_t;

	// Per-channel status back to the top level
	typedef struct packed {
		logic [WORD_W-1:0] rd_word;
		logic              irq_next;
	} chan_stat_t;

	// Offsets served by channel flops rather than plain storage
	function automatic logic is_chan_word(input logic [OFF_W-1:0] off);
		return (off == OFF_COMP1) || (off == OFF_LOAD) || (off == OFF_CNTR) ||
			(off == OFF_CTRL) || (off == OFF_SCTRL) || (off == OFF_CSCTRL);
	endfunction

endpackage

// ===== rtl/core/tmr_stream_if.sv =====
interface tmr_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/core/tmr_word_mem.sv =====
module tmr_word_mem (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             wr_en,
	input  logic [tmr_pkg::ADDR_W-1:0]       wr_addr,
	input  logic [tmr_pkg::WORD_W-1:0]       wr_data,
	input  logic                             rd_en,
	input  logic [tmr_pkg::ADDR_W-1:0]       rd_addr,
	output logic [tmr_pkg::WORD_W-1:0]       rd_word
);

	logic [tmr_pkg::WORD_W-1:0]     mem [tmr_pkg::WORD_COUNT];
	logic [tmr_pkg::WORD_COUNT-1:0] vld_q;
	logic [tmr_pkg::WORD_W-1:0]     rd_data_q;
	logic                           rd_vld_q;

	// Storage array and registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	// Track written entries so untouched words read as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_vld_q <= vld_q[rd_addr];
			end
		end
	end

	assign rd_word = rd_vld_q ? rd_data_q : '0;

endmodule

// ===== rtl/core/tmr_channel.sv =====
module tmr_channel (
	input  logic                   clk,
	input  logic                   arst_n,
	input  tmr_pkg::chan_cmd_t     cmd,
	output tmr_pkg::chan_stat_t    stat
);

	logic [tmr_pkg::WORD_W-1:0] comp1_q, load_q, ctrl_q, sctrl_q, csctrl_q, count_q;
	logic [tmr_pkg::WORD_W-1:0] comp1_d, load_d, ctrl_d, sctrl_d, csctrl_d, count_d;
	logic [tmr_pkg::PRE_W-1:0]  pre_q, pre_d;
	logic [3:0]                 pcs;
	logic [tmr_pkg::PRE_W:0]    last_wide;
	logic [tmr_pkg::PRE_W-1:0]  last;
	logic                       running;
	logic [tmr_pkg::WORD_W-1:0] sc_m, cs_m;
	logic [tmr_pkg::WORD_W-1:0] rd_sel;
	logic                       irq_now;

	assign sc_m = tmr_pkg::SC_TCF | tmr_pkg::SC_TOF;
	assign cs_m = tmr_pkg::CS_TCF1 | tmr_pkg::CS_TCF2;

	// Prescaler terminal value from PCS
	assign pcs       = ctrl_q[tmr_pkg::PCS_LSB +: 4];
	assign last_wide = (pcs[3]) ? ((8'd1 << pcs[2:0]) - 8'd1) : 8'd0;
	assign last      = last_wide[tmr_pkg::PRE_W-1:0];
	assign running   = ((ctrl_q & tmr_pkg::CM_MASK) != '0) && cmd.run_en;

	// Next state for bus writes, restarts and ticks
	always_comb begin
		comp1_d  = comp1_q;
		load_d   = load_q;
		ctrl_d   = ctrl_q;
		sctrl_d  = sctrl_q;
		csctrl_d = csctrl_q;
		count_d  = count_q;
		pre_d    = pre_q;
		if (cmd.wr_sel) begin
			case (cmd.off)
				tmr_pkg::OFF_COMP1: begin
					comp1_d = cmd.data;
					count_d = load_q;
					pre_d   = '0;
				end
				tmr_pkg::OFF_LOAD: begin
					load_d  = cmd.data;
					count_d = cmd.data;
					pre_d   = '0;
				end
				tmr_pkg::OFF_CTRL: begin
					ctrl_d  = cmd.data;
					count_d = load_q;
					pre_d   = '0;
				end
				tmr_pkg::OFF_SCTRL: begin
					sctrl_d = (cmd.data & ~sc_m) | (sctrl_q & sc_m & cmd.data);
				end
				tmr_pkg::OFF_CSCTRL: begin
					csctrl_d = (cmd.data & ~cs_m) | (csctrl_q & cs_m & cmd.data);
				end
				default: begin
				end
			endcase
		end
		if (cmd.restart_all) begin
			count_d = load_q;
			pre_d   = '0;
		end
		if (cmd.tick && running) begin
			if (pre_q < last) begin
				pre_d = pre_q + 1'b1;
			end else begin
				pre_d = '0;
				if (count_q == comp1_q) begin
					sctrl_d  = sctrl_q | tmr_pkg::SC_TCF;
					csctrl_d = csctrl_q | tmr_pkg::CS_TCF1;
					count_d  = load_q;
				end else begin
					count_d = count_q + 1'b1;
				end
			end
		end
	end

	// Channel state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			comp1_q  <= '0;
			load_q   <= '0;
			ctrl_q   <= '0;
			sctrl_q  <= '0;
			csctrl_q <= '0;
			count_q  <= '0;
			pre_q    <= '0;
		end else begin
			comp1_q  <= comp1_d;
			load_q   <= load_d;
			ctrl_q   <= ctrl_d;
			sctrl_q  <= sctrl_d;
			csctrl_q <= csctrl_d;
			count_q  <= count_d;
			pre_q    <= pre_d;
		end
	end

	// Read mux over the channel's own words
	always_comb begin
		case (cmd.off)
			tmr_pkg::OFF_COMP1:  rd_sel = comp1_q;
			tmr_pkg::OFF_LOAD:   rd_sel = load_q;
			tmr_pkg::OFF_CNTR:   rd_sel = count_q;
			tmr_pkg::OFF_CTRL:   rd_sel = ctrl_q;
			tmr_pkg::OFF_SCTRL:  rd_sel = sctrl_q;
			tmr_pkg::OFF_CSCTRL: rd_sel = csctrl_q;
			default:             rd_sel = '0;
		endcase
	end

	// Interrupt level after this item
	assign irq_now =
		(((sctrl_d & tmr_pkg::SC_TCF) != '0) && ((sctrl_d & tmr_pkg::SC_TCFIE) != '0)) ||
		(((sctrl_d & tmr_pkg::SC_TOF) != '0) && ((sctrl_d & tmr_pkg::SC_TOFIE) != '0)) ||
		(((csctrl_d & tmr_pkg::CS_TCF1) != '0) && ((csctrl_d & tmr_pkg::CS_TCF1EN) != '0)) ||
		(((csctrl_d & tmr_pkg::CS_TCF2) != '0) && ((csctrl_d & tmr_pkg::CS_TCF2EN) != '0));

	assign stat = {rd_sel, irq_now};

endmodule

// ===== rtl/core/four_channel_modulo_timer.sv =====
// Output: each accepted transfer's result is captured in the output register on acceptance.
// Throughput: one item per cycle unless the receiver stalls; every item completes in a
//   single pass through the channel update logic and the storage read port.
// Reset: arst_n clears all channel registers, counters and prescalers to zero, sets
//   the enable word to 1 and marks every plain storage word as reading zero.
`include "assert_macros.svh"

module four_channel_modulo_timer #(
	parameter int NUM_CHANNELS = tmr_pkg::NUM_CHANNELS_DEF
) (
	input logic          clk,
	input logic          arst_n,
	tmr_stream_if.sink   req,
	tmr_stream_if.source rsp
);

	localparam int ACTIVE_CH =
		(NUM_CHANNELS < tmr_pkg::MAX_CH) ? NUM_CHANNELS : tmr_pkg::MAX_CH;

	logic                               acc;
	logic                               is_wr, is_rd, is_tick;
	logic [tmr_pkg::CH_IDX_W-1:0]       ch_idx;
	logic [tmr_pkg::OFF_W-1:0]          off;
	logic                               ch_active;
	logic                               restart_all;
	logic                               enbl_wr;
	logic [tmr_pkg::WORD_W-1:0]         enbl_q;
	tmr_pkg::chan_cmd_t                 chan_cmd  [tmr_pkg::MAX_CH];
	tmr_pkg::chan_stat_t                chan_stat [tmr_pkg::MAX_CH];
	logic                               irq_any;
	logic [tmr_pkg::WORD_W-1:0]         rd_val;
	logic                               use_mem;
	logic                               mem_wr;
	logic [tmr_pkg::WORD_W-1:0]         mem_word;
	logic                               valid_s1;
	logic [tmr_pkg::WORD_W-1:0]         rd_s1;
	logic                               irq_s1;
	logic                               use_mem_s1;

	// Input decode
	assign req.ready = !valid_s1 || rsp.ready;
	assign acc       = req.valid && req.ready;
	assign is_wr     = acc && (req.payload.kind == tmr_pkg::KIND_WRITE);
	assign is_rd     = acc && (req.payload.kind == tmr_pkg::KIND_READ);
	assign is_tick   = acc && (req.payload.kind == tmr_pkg::KIND_TICK);
	assign ch_idx    = req.payload.word_address[tmr_pkg::ADDR_W-1 -: tmr_pkg::CH_IDX_W];
	assign off       = req.payload.word_address[tmr_pkg::OFF_W-1:0];
	assign ch_active = ({1'b0, ch_idx} < 3'(ACTIVE_CH));
	assign restart_all = is_wr && ch_active && (off == tmr_pkg::OFF_ENBL);
	assign enbl_wr   = is_wr && (req.payload.word_address == tmr_pkg::ENBL_ADDR);

	// Channel bank
	for (genvar c = 0; c < tmr_pkg::MAX_CH; c++) begin : g_ch
		if (c < ACTIVE_CH) begin : g_on
			always_comb begin
				chan_cmd[c].wr_sel      = is_wr && ch_active &&
					(ch_idx == tmr_pkg::CH_IDX_W'(c));
				chan_cmd[c].restart_all = restart_all;
				chan_cmd[c].tick        = is_tick;
				chan_cmd[c].run_en      = enbl_q[c];
				chan_cmd[c].off         = off;
				chan_cmd[c].data        = req.payload.write_data;
			end
			tmr_channel u_ch (
				.clk    (clk),
				.arst_n (arst_n),
				.cmd    (chan_cmd[c]),
				.stat   (chan_stat[c])
			);
		end else begin : g_off
			assign chan_cmd[c]  = '0;
			assign chan_stat[c] = '0;
		end
	end

	// Shared interrupt over all channels
	always_comb begin
		irq_any = 1'b0;
		for (int c = 0; c < tmr_pkg::MAX_CH; c++) begin
			irq_any = irq_any | chan_stat[c].irq_next;
		end
	end

	// Enable word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enbl_q <= tmr_pkg::ENBL_RST;
		end else if (enbl_wr) begin
			enbl_q <= req.payload.write_data;
		end
	end

	// Read source select
	always_comb begin
		rd_val  = '0;
		use_mem = 1'b0;
		if (is_rd && ch_active) begin
			if (tmr_pkg::is_chan_word(off)) begin
				rd_val = chan_stat[ch_idx].rd_word;
			end else if (req.payload.word_address == tmr_pkg::ENBL_ADDR) begin
				rd_val = enbl_q;
			end else begin
				use_mem = 1'b1;
			end
		end
	end

	// Plain storage words
	assign mem_wr = is_wr && ch_active;

	tmr_word_mem u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (mem_wr),
		.wr_addr (req.payload.word_address),
		.wr_data (req.payload.write_data),
		.rd_en   (use_mem),
		.rd_addr (req.payload.word_address),
		.rd_word (mem_word)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			rd_s1      <= rd_val;
			irq_s1     <= irq_any;
			use_mem_s1 <= use_mem;
		end
	end

	assign rsp.valid   = valid_s1;
	assign rsp.payload = {(use_mem_s1 ? mem_word : rd_s1), irq_s1};

	// Checks
	`ASSERT_NEXT(a_accept_fills, acc, valid_s1)
	`ASSERT_NEXT(a_nonread_zero, acc && !is_rd, rsp.payload.read_data == '0)
	`ASSERT_NEXT(a_enbl_write, enbl_wr, enbl_q == $past(req.payload.write_data))
	`ASSERT_IMPL(a_ready_free, !valid_s1, req.ready)

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;
	import tmr_pkg::*;

	// Kind code that the block leaves without effect
	localparam logic [1:0] KIND_NOP = 2'd3;
	localparam int DIRECT_OPS = 30;
	localparam int RANDOM_OPS = 1400;
	localparam int HOLD_START = 3000;
	localparam int HOLD_LEN = 400;

	logic clk;
	logic arst_n;

	tmr_stream_if #(.payload_t(req_t)) req_bus ();
	tmr_stream_if #(.payload_t(rsp_t)) rsp_bus ();

	four_channel_modulo_timer DUT (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_bus),
		.rsp(rsp_bus)
	);

	// Shadow copy of the timer state
	logic [WORD_W-1:0] shadow_words[WORD_COUNT];
	logic [WORD_W-1:0] shadow_count[MAX_CH];
	logic [PRE_W-1:0] shadow_prescale[MAX_CH];

	req_t bus_ops_pending[$];
	rsp_t bus_replies_due[$];
	rsp_t reply_want;
	rsp_t reply_calc;

	int mismatches = 0;
	int ticks_seen = 0;
	int reads_seen = 0;
	int writes_seen = 0;
	int compare_hits = 0;
	int irq_replies = 0;
	int ops_built = 0;

	int gap_left;
	int launches;
	bit send_calm;
	int stall_left;
	int replies_taken;
	bit take_calm;
	bit long_hold;
	int hold_clock;

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic logic [ADDR_W-1:0] word_at(int c, logic [OFF_W-1:0] off);
		return {CH_IDX_W'(c), off};
	endfunction

	function automatic void reload_channel(int c);
		shadow_count[c] = shadow_words[word_at(c, OFF_LOAD)];
		shadow_prescale[c] = '0;
	endfunction

	// Advance the shadow timer by one bus operation and form its reply
	task automatic shadow_timer_step(input req_t op, output rsp_t reply);
		logic [OFF_W-1:0] off;
		logic [WORD_W-1:0] old;
		logic [WORD_W-1:0] keep;
		logic [WORD_W-1:0] ctrl;
		logic [WORD_W-1:0] sc;
		logic [WORD_W-1:0] cs;
		int pcs;
		int last;
		off = op.word_address[OFF_W-1:0];
		reply = '0;
		case (op.kind)
			KIND_WRITE: begin
				old = shadow_words[op.word_address];
				if (off == OFF_SCTRL) begin
					keep = SC_TCF | SC_TOF;
					shadow_words[op.word_address] = (op.write_data & ~keep) |
						(old & keep & op.write_data);
				end else if (off == OFF_CSCTRL) begin
					keep = CS_TCF1 | CS_TCF2;
					shadow_words[op.word_address] = (op.write_data & ~keep) |
						(old & keep & op.write_data);
				end else begin
					shadow_words[op.word_address] = op.write_data;
					if (off == OFF_ENBL) begin
						for (int c = 0; c < MAX_CH; c++)
							reload_channel(c);
					end else if (off == OFF_CTRL || off == OFF_COMP1 || off == OFF_LOAD) begin
						reload_channel(int'(op.word_address[ADDR_W-1:OFF_W]));
					end
				end
			end
			KIND_READ: begin
				if (off == OFF_CNTR)
					reply.read_data = shadow_count[op.word_address[ADDR_W-1:OFF_W]];
				else
					reply.read_data = shadow_words[op.word_address];
			end
			KIND_TICK: begin
				for (int c = 0; c < MAX_CH; c++) begin
					ctrl = shadow_words[word_at(c, OFF_CTRL)];
					if ((ctrl & CM_MASK) != '0 && shadow_words[ENBL_ADDR][c]) begin
						pcs = int'((ctrl & PCS_MASK) >> PCS_LSB);
						last = (pcs >= 8) ? ((1 << (pcs - 8)) - 1) : 0;
						if (int'(shadow_prescale[c]) < last) begin
							shadow_prescale[c] = shadow_prescale[c] + 1'b1;
						end else begin
							shadow_prescale[c] = '0;
							if (shadow_count[c] == shadow_words[word_at(c, OFF_COMP1)]) begin
								shadow_words[word_at(c, OFF_SCTRL)] |= SC_TCF;
								shadow_words[word_at(c, OFF_CSCTRL)] |= CS_TCF1;
								shadow_count[c] = shadow_words[word_at(c, OFF_LOAD)];
								compare_hits++;
							end else begin
								shadow_count[c] = shadow_count[c] + 1'b1;
							end
						end
					end
				end
			end
			default: ;
		endcase
		// Combine every flag with its enable across the channels
		for (int c = 0; c < MAX_CH; c++) begin
			sc = shadow_words[word_at(c, OFF_SCTRL)];
			cs = shadow_words[word_at(c, OFF_CSCTRL)];
			if (((sc & SC_TCF) != '0 && (sc & SC_TCFIE) != '0) ||
				((sc & SC_TOF) != '0 && (sc & SC_TOFIE) != '0) ||
				((cs & CS_TCF1) != '0 && (cs & CS_TCF1EN) != '0) ||
				((cs & CS_TCF2) != '0 && (cs & CS_TCF2EN) != '0))
				reply.irq_level = 1'b1;
		end
	endtask

	task automatic queue_bus_op(logic [1:0] kind, logic [ADDR_W-1:0] addr,
		logic [WORD_W-1:0] data);
		req_t op;
		op.kind = kind;
		op.word_address = addr;
		op.write_data = data;
		bus_ops_pending.push_back(op);
		ops_built++;
	endtask

	// Sender: offer the next pending operation after its drawn gap
	always @(posedge clk) begin
		if (!arst_n) begin
			req_bus.valid <= 1'b0;
			req_bus.payload <= '0;
			gap_left <= 0;
			launches <= 0;
			send_calm <= 1'b0;
		end else if (!req_bus.valid || req_bus.ready) begin
			if (gap_left > 0) begin
				req_bus.valid <= 1'b0;
				gap_left <= gap_left - 1;
			end else if (bus_ops_pending.size() > 0) begin
				req_bus.payload <= bus_ops_pending.pop_front();
				req_bus.valid <= 1'b1;
				gap_left <= send_calm ? 0 : $urandom_range(0, 15);
				launches <= launches + 1;
				if (launches % 150 == 149)
					send_calm <= ~send_calm;
			end else begin
				req_bus.valid <= 1'b0;
			end
		end
	end

	// Receiver: outside calm phases, drop ready after each transfer for a randomly drawn stall
	always @(posedge clk) begin
		if (!arst_n) begin
			rsp_bus.ready <= 1'b0;
			stall_left <= 0;
			replies_taken <= 0;
			take_calm <= 1'b0;
		end else if (rsp_bus.valid && rsp_bus.ready) begin
			if (take_calm) begin
				stall_left <= 0;
				rsp_bus.ready <= !long_hold;
			end else begin
				stall_left <= $urandom_range(0, 15);
				rsp_bus.ready <= 1'b0;
			end
			replies_taken <= replies_taken + 1;
			if (replies_taken % 120 == 119)
				take_calm <= ~take_calm;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			rsp_bus.ready <= (stall_left == 1) && !long_hold;
		end else begin
			rsp_bus.ready <= !long_hold;
		end
	end

	// Hold off the receiver once for a long stretch so the block backs up
	always @(posedge clk) begin
		if (!arst_n) begin
			hold_clock <= 0;
			long_hold <= 1'b0;
		end else begin
			hold_clock <= hold_clock + 1;
			long_hold <= (hold_clock >= HOLD_START) && (hold_clock < HOLD_START + HOLD_LEN);
		end
	end

	// Check each reply against the oldest prediction; predict each accepted operation
	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp_bus.valid && rsp_bus.ready) begin
				if (bus_replies_due.size() == 0) begin
					$display("%0t: reply with none expected, got data %h irq %b", $time,
						rsp_bus.payload.read_data, rsp_bus.payload.irq_level);
					mismatches++;
				end else begin
					reply_want = bus_replies_due.pop_front();
					if (rsp_bus.payload.read_data !== reply_want.read_data) begin
						$display("%0t: read_data expected %h, got %h", $time,
							reply_want.read_data, rsp_bus.payload.read_data);
						mismatches++;
					end
					if (rsp_bus.payload.irq_level !== reply_want.irq_level) begin
						$display("%0t: irq_level expected %b, got %b", $time,
							reply_want.irq_level, rsp_bus.payload.irq_level);
						mismatches++;
					end
					if (reply_want.irq_level)
						irq_replies++;
				end
			end
			if (req_bus.valid && req_bus.ready) begin
				shadow_timer_step(req_bus.payload, reply_calc);
				bus_replies_due.push_back(reply_calc);
				case (req_bus.payload.kind)
					KIND_WRITE: writes_seen++;
					KIND_READ: reads_seen++;
					KIND_TICK: ticks_seen++;
					default: ;
				endcase
			end
		end
	end

	initial begin
		#3_000_000;
		$display("timeout: %0d replies still due", bus_replies_due.size());
		$display("four_channel_modulo_timer verification failed");
		$finish;
	end

	initial begin
		int c;
		int r;
		int n;
		int pcs;
		logic [WORD_W-1:0] ld;
		logic [WORD_W-1:0] cmp;

		req_bus.valid = 1'b0;
		req_bus.payload = '0;
		rsp_bus.ready = 1'b0;
		arst_n = 1'b0;
		foreach (shadow_words[i])
			shadow_words[i] = '0;
		shadow_words[ENBL_ADDR] = ENBL_RST;
		for (int i = 0; i < MAX_CH; i++) begin
			shadow_count[i] = '0;
			shadow_prescale[i] = '0;
		end

		// Directed: reset values, one full period with flags, flag clears, restarts
		queue_bus_op(KIND_READ, ENBL_ADDR, 16'h0000);
		queue_bus_op(KIND_READ, 6'd63, 16'hFFFF);
		queue_bus_op(KIND_WRITE, word_at(0, OFF_COMP1), 16'd3);
		queue_bus_op(KIND_WRITE, word_at(0, OFF_LOAD), 16'd0);
		queue_bus_op(KIND_WRITE, word_at(0, OFF_CSCTRL), CS_TCF1EN | CS_TCF2EN);
		queue_bus_op(KIND_WRITE, word_at(0, OFF_SCTRL), SC_TCFIE | SC_TOFIE);
		queue_bus_op(KIND_WRITE, word_at(0, OFF_CTRL), 16'h2000);
		repeat (5)
			queue_bus_op(KIND_TICK, word_at(0, OFF_CNTR), 16'h0000);
		queue_bus_op(KIND_READ, word_at(0, OFF_CNTR), 16'h0000);
		queue_bus_op(KIND_READ, word_at(0, OFF_SCTRL), 16'h0000);
		queue_bus_op(KIND_WRITE, word_at(0, OFF_SCTRL), 16'hFFFF);
		queue_bus_op(KIND_WRITE, word_at(0, OFF_SCTRL), 16'h0000);
		queue_bus_op(KIND_WRITE, word_at(0, OFF_CSCTRL), 16'h0000);
		// Slowest prescale on channel 1, enable all, restart through another block's ENBL
		queue_bus_op(KIND_WRITE, word_at(1, OFF_CTRL), 16'hFE00);
		queue_bus_op(KIND_WRITE, ENBL_ADDR, 16'hFFFF);
		queue_bus_op(KIND_WRITE, word_at(2, OFF_ENBL), 16'h0000);
		queue_bus_op(KIND_TICK, 6'd0, 16'hFFFF);
		queue_bus_op(KIND_READ, word_at(1, OFF_CNTR), 16'h0000);
		queue_bus_op(KIND_NOP, 6'd63, 16'hFFFF);
		// Write to the counter only stores the word; the read returns the live count
		queue_bus_op(KIND_WRITE, word_at(2, OFF_CNTR), 16'hFFFF);
		queue_bus_op(KIND_READ, word_at(2, OFF_CNTR), 16'h0000);
		queue_bus_op(KIND_WRITE, word_at(3, 4'd1), 16'hA5A5);
		queue_bus_op(KIND_READ, word_at(3, 4'd1), 16'h0000);
		queue_bus_op(KIND_READ, word_at(2, OFF_ENBL), 16'h0000);

		// Random: mostly configured channels ticking, with noise in between
		while (ops_built < DIRECT_OPS + RANDOM_OPS) begin
			if ($urandom_range(0, 9) < 7) begin
				c = $urandom_range(0, MAX_CH - 1);
				r = $urandom_range(0, 9);
				ld = (r == 0) ? 16'($urandom) : (r == 1) ? 16'hFFF8 : 16'($urandom_range(0, 40));
				cmp = ld + 16'($urandom_range(0, 12));
				queue_bus_op(KIND_WRITE, word_at(c, OFF_SCTRL), 16'($urandom));
				queue_bus_op(KIND_WRITE, word_at(c, OFF_CSCTRL), 16'($urandom));
				if ($urandom_range(0, 3) != 0)
					queue_bus_op(KIND_WRITE, ENBL_ADDR, 16'($urandom) | (16'd1 << c));
				if ($urandom_range(0, 1) == 0) begin
					queue_bus_op(KIND_WRITE, word_at(c, OFF_LOAD), ld);
					queue_bus_op(KIND_WRITE, word_at(c, OFF_COMP1), cmp);
				end else begin
					queue_bus_op(KIND_WRITE, word_at(c, OFF_COMP1), cmp);
					queue_bus_op(KIND_WRITE, word_at(c, OFF_LOAD), ld);
				end
				r = $urandom_range(0, 9);
				pcs = (r < 6) ? $urandom_range(0, 7) : (r < 9) ? $urandom_range(8, 10) :
					$urandom_range(11, 15);
				queue_bus_op(KIND_WRITE, word_at(c, OFF_CTRL),
					{3'($urandom_range(($urandom_range(0, 9) == 0) ? 0 : 1, 7)),
					4'(pcs), 9'($urandom)});
				n = $urandom_range(8, 40);
				repeat (n) begin
					r = $urandom_range(0, 9);
					if (r < 7) begin
						queue_bus_op(KIND_TICK, 6'($urandom), 16'($urandom));
					end else if (r < 9) begin
						c = $urandom_range(0, MAX_CH - 1);
						case ($urandom_range(0, 3))
							0: queue_bus_op(KIND_READ, word_at(c, OFF_CNTR), 16'($urandom));
							1: queue_bus_op(KIND_READ, word_at(c, OFF_SCTRL), 16'($urandom));
							2: queue_bus_op(KIND_READ, word_at(c, OFF_CSCTRL), 16'($urandom));
							default: queue_bus_op(KIND_READ, 6'($urandom), 16'($urandom));
						endcase
					end else begin
						c = $urandom_range(0, MAX_CH - 1);
						queue_bus_op(KIND_WRITE, word_at(c, ($urandom_range(0, 1) == 0) ?
							OFF_SCTRL : OFF_CSCTRL), 16'($urandom));
					end
				end
			end else begin
				repeat ($urandom_range(1, 6))
					queue_bus_op(2'($urandom), 6'($urandom), 16'($urandom));
			end
		end

		// Hold reset, then release between clock edges
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Drain: all operations sent and every reply taken
		while (bus_ops_pending.size() > 0 || req_bus.valid || bus_replies_due.size() > 0)
			@(negedge clk);
		repeat (10) @(negedge clk);

		$display("Covered %0d writes, %0d reads and %0d ticks over four channels.",
			writes_seen, reads_seen, ticks_seen);
		$display("Saw %0d compare matches and %0d replies with the interrupt raised.",
			compare_hits, irq_replies);
		if (bus_replies_due.size() != 0)
			$display("%0t: %0d replies never arrived", $time, bus_replies_due.size());
		if (mismatches == 0 && bus_replies_due.size() == 0) begin
			$display("four_channel_modulo_timer verification clean");
		end else begin
			$display("four_channel_modulo_timer verification failed");
		end
		$finish;
	end

endmodule
